/* rtl/dpdsc_pkg.sv */
// dpdsc_pkg: shared types, codes and lfsr helpers for the main-link descrambler
package dpdsc_pkg;

    // result kinds
    localparam logic [2:0] KIND_SCR_DESYNC   = 3'd0;
    localparam logic [2:0] KIND_FRAME_DESYNC = 3'd1;
    localparam logic [2:0] KIND_FILL         = 3'd2;
    localparam logic [2:0] KIND_BS           = 3'd3;
    localparam logic [2:0] KIND_DATA         = 3'd4;

    // control symbol codes
    localparam logic [7:0] SYM_SR = 8'h1c;
    localparam logic [7:0] SYM_BS = 8'hbc;
    localparam logic [7:0] SYM_BE = 8'hfb;
    localparam logic [7:0] SYM_FS = 8'hfe;

    // scrambler constants
    localparam logic [15:0] LFSR_TAPS  = 16'h001c;
    localparam logic [15:0] LFSR_RESET = 16'h0001;
    localparam logic [7:0]  SEED_LOW   = 8'hff;

    // fill collection
    localparam logic [7:0] MIN_FILL_RESET = 8'd4;
    localparam logic [7:0] MIN_FILL_FLOOR = 8'd2;
    localparam logic [7:0] FILL_MAX       = 8'hff;
    localparam logic [1:0] BS_SKIP        = 2'd3;

    // result queue depth, a power of two of at least two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [15:0] next;
        logic [7:0]  out;
    } t_lfsr_res;

    // up to two results caused by one symbol; the second one never carries data
    typedef struct packed {
        logic [1:0] count;
        logic [2:0] kind0;
        logic [7:0] data0;
        logic [2:0] kind1;
    } t_res_pair;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } t_entry;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = v[k];
        end
        return r;
    endfunction

    // eight-bit advance of the scrambler, output collected lsb first
    function automatic t_lfsr_res lfsr_run(input logic [15:0] v);
        t_lfsr_res  r;
        logic [15:0] s;
        logic [7:0]  o;
        logic        b;
        s = v;
        o = '0;
        for (int k = 0; k < 8; k++) begin
            b = s[15];
            o = {b, o[7:1]};
            if (b) begin
                s = s ^ LFSR_TAPS;
            end
            s = {s[14:0], b};
        end
        r.next = s;
        r.out  = o;
        return r;
    endfunction

endpackage

/* rtl/dpdsc_core.sv */
// dpdsc_core: lock state, scrambler lfsr and per-symbol result decision
module dpdsc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_sym,
    input  logic                 i_ctl,
    input  logic [7:0]           i_min_fill,
    output dpdsc_pkg::t_res_pair o_res
);

    logic [15:0] r_lfsr, n_lfsr;
    logic        r_scr_locked, n_scr_locked;
    logic        r_frame_locked, n_frame_locked;
    logic        r_in_fill, n_in_fill;
    logic [7:0]  r_fill_count, n_fill_count;
    logic        r_fill_mismatch, n_fill_mismatch;
    logic [1:0]  r_skip, n_skip;

    logic [15:0]          lfsr_src;
    logic                 do_run;
    dpdsc_pkg::t_lfsr_res run;
    logic [7:0]           need;
    dpdsc_pkg::t_res_pair res;

    assign need = (i_min_fill < dpdsc_pkg::MIN_FILL_FLOOR) ? dpdsc_pkg::MIN_FILL_FLOOR
                                                           : i_min_fill;
    assign run  = dpdsc_pkg::lfsr_run(lfsr_src);

    // next state and results for the symbol in this transfer
    always_comb begin
        lfsr_src        = r_lfsr;
        do_run          = 1'b0;
        n_scr_locked    = r_scr_locked;
        n_frame_locked  = r_frame_locked;
        n_in_fill       = r_in_fill;
        n_fill_count    = r_fill_count;
        n_fill_mismatch = r_fill_mismatch;
        n_skip          = r_skip;
        res             = '0;

        if (r_skip != 2'd0) begin
            // symbols after blanking start are consumed unseen
            n_skip = r_skip - 2'd1;
            do_run = r_scr_locked;
        end else if (r_in_fill) begin
            if (r_scr_locked) begin
                do_run = 1'b1;
                if (i_ctl) begin
                    n_in_fill = 1'b0;
                end
            end else if (i_ctl) begin
                // end of fill: take lock if enough clean bytes were seen
                n_in_fill = 1'b0;
                if ((r_fill_count >= need) && !r_fill_mismatch) begin
                    n_scr_locked = 1'b1;
                    do_run       = 1'b1;
                end
            end else begin
                do_run = 1'b1;
                if (r_fill_count == 8'd0) begin
                    lfsr_src = {dpdsc_pkg::rev8(i_sym), dpdsc_pkg::SEED_LOW};
                end else begin
                    if (r_fill_count == 8'd1) begin
                        lfsr_src = {dpdsc_pkg::rev8(i_sym), r_lfsr[7:0]};
                    end
                    if (run.out != i_sym) begin
                        n_fill_mismatch = 1'b1;
                    end
                end
                if (r_fill_count != dpdsc_pkg::FILL_MAX) begin
                    n_fill_count = r_fill_count + 8'd1;
                end
            end
        end else begin
            do_run = r_scr_locked;
            if (!i_ctl) begin
                if (r_scr_locked) begin
                    res.count = 2'd1;
                    res.kind0 = dpdsc_pkg::KIND_DATA;
                    res.data0 = i_sym ^ run.out;
                end
            end else if (i_sym == dpdsc_pkg::SYM_SR) begin
                n_frame_locked = 1'b1;
            end else if (i_sym == dpdsc_pkg::SYM_BS) begin
                if (r_scr_locked) begin
                    n_frame_locked = 1'b1;
                    n_skip         = dpdsc_pkg::BS_SKIP;
                    if (!r_frame_locked) begin
                        res.count = 2'd2;
                        res.kind0 = dpdsc_pkg::KIND_FRAME_DESYNC;
                        res.kind1 = dpdsc_pkg::KIND_BS;
                    end else begin
                        res.count = 2'd1;
                        res.kind0 = dpdsc_pkg::KIND_BS;
                    end
                end
            end else if (i_sym == dpdsc_pkg::SYM_FS) begin
                n_in_fill = 1'b1;
                if (!r_scr_locked) begin
                    n_fill_count    = '0;
                    n_fill_mismatch = 1'b0;
                    res.count       = 2'd2;
                    res.kind0       = dpdsc_pkg::KIND_SCR_DESYNC;
                    res.kind1       = dpdsc_pkg::KIND_FILL;
                end else if (!r_frame_locked) begin
                    res.count = 2'd2;
                    res.kind0 = dpdsc_pkg::KIND_FRAME_DESYNC;
                    res.kind1 = dpdsc_pkg::KIND_FILL;
                end else begin
                    res.count = 2'd1;
                    res.kind0 = dpdsc_pkg::KIND_FILL;
                end
            end
        end

        n_lfsr = do_run ? run.next : lfsr_src;
    end

    // state registers, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr          <= dpdsc_pkg::LFSR_RESET;
            r_scr_locked    <= 1'b0;
            r_frame_locked  <= 1'b0;
            r_in_fill       <= 1'b0;
            r_fill_count    <= '0;
            r_fill_mismatch <= 1'b0;
            r_skip          <= '0;
        end else if (i_valid) begin
            r_lfsr          <= n_lfsr;
            r_scr_locked    <= n_scr_locked;
            r_frame_locked  <= n_frame_locked;
            r_in_fill       <= n_in_fill;
            r_fill_count    <= n_fill_count;
            r_fill_mismatch <= n_fill_mismatch;
            r_skip          <= n_skip;
        end
    end

    assign o_res = i_valid ? res : '0;

    // lock is only ever taken at the end of a fill run
    a_lock_from_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_scr_locked) |-> $past(r_in_fill))
        else $error("scrambler lock taken outside a fill run");

    // skipped symbols never give results
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (r_skip != 2'd0)) |-> (o_res.count == 2'd0))
        else $error("result produced on a skipped symbol");

    // blanking start skips only happen once the scrambler is locked
    a_skip_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != 2'd0) |-> r_scr_locked)
        else $error("symbol skip pending without scrambler lock");

endmodule

/* rtl/dpdsc_outq.sv */
// dpdsc_outq: small result queue taking up to two results per cycle
module dpdsc_outq #(
    parameter int DEPTH = dpdsc_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dpdsc_pkg::t_res_pair i_res,
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_data,
    output logic                 o_last
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    dpdsc_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    logic          pop;
    logic [PW-1:0] wptr1;
    logic [CW-1:0] push_cnt;
    dpdsc_pkg::t_entry e0, e1;

    assign pop      = o_valid && i_ready;
    assign wptr1    = r_wptr + PW'(1);
    assign push_cnt = CW'(i_res.count);
    assign o_room   = (r_count <= CW'(DEPTH - 2));
    assign o_valid  = (r_count != '0);

    assign e0.kind = i_res.kind0;
    assign e0.data = i_res.data0;
    assign e0.last = (i_res.count == 2'd1);
    assign e1.kind = i_res.kind1;
    assign e1.data = '0;
    assign e1.last = 1'b1;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_mem[r_wptr] <= e0;
        end
        if (i_res.count == 2'd2) begin
            r_mem[wptr1] <= e1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PW'(i_res.count);
            r_rptr  <= r_rptr + PW'(pop);
            r_count <= r_count + push_cnt - CW'(pop);
        end
    end

    assign o_kind = r_mem[r_rptr].kind;
    assign o_data = r_mem[r_rptr].data;
    assign o_last = r_mem[r_rptr].last;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.count != 2'd0) |-> o_room)
        else $error("results pushed without room");

    a_level_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pop && (i_res.count == 2'd0)) |=> $stable(r_count))
        else $error("queue level moved without a transfer");

endmodule

/* rtl/dp_main_link_descrambler_lock.sv */
// dp_main_link_descrambler_lock: top level of the main-link descrambler
// One decoded link symbol (byte on s_axis_tdata, K flag on s_axis_tuser) is
// taken per clock while the output side drains: the lock state and the
// 8-bit-per-symbol scrambler update in the same cycle as the input transfer,
// and the results land in a four-entry queue (default depth) feeding the
// master side. A symbol gives zero, one or two results; FS while not fully
// locked and BS while only frame-unlocked give two, and the queue absorbs the
// extra one. Input is held off only while fewer than two queue entries are
// free. min_fill_symbols is written through the cfg channel, always ready,
// and should only change while the link is idle.
module dp_main_link_descrambler_lock #(
    parameter int QUEUE_DEPTH = dpdsc_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data,
    // symbol input
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] symbol_byte
    input  logic       s_axis_tuser,   // [0] is_control
    // result output
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_value
    output logic [2:0] m_axis_tuser,   // [2:0] event_kind
    output logic       m_axis_tlast    // last_of_run
);

    logic [7:0]           r_min_fill;
    logic                 in_xfer;
    logic                 room;
    dpdsc_pkg::t_res_pair res;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fill <= dpdsc_pkg::MIN_FILL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_min_fill <= i_cfg_data;
        end
    end

    assign s_axis_tready = room;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    dpdsc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_xfer),
        .i_sym      (s_axis_tdata),
        .i_ctl      (s_axis_tuser),
        .i_min_fill (r_min_fill),
        .o_res      (res)
    );

    dpdsc_outq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (m_axis_tuser),
        .o_data  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule
